>>> rtl/assert_macros.svh
// Assertion macros used by the datapath of the binomial coefficient core.
// No dependencies; the bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define BC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BC_ASSERT(lbl, clk, rstn, prop, msg)
`define BC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

>>> rtl/bc_pkg.sv
// Types and constants shared by the binomial coefficient controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package bc_pkg;

  // Operand and product widths.
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned HALF_W  = DATA_W / 2;
  // The divisor i+1 never passes 35 before the running value saturates.
  localparam int unsigned STEP_W  = 8;
  // Quotient bits retired per division cycle.
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned DIV_CYCLES = PROD_W / DIGIT_W;
  // Four 32x32 partial products per step.
  localparam int unsigned PP_COUNT = 4;
  localparam int unsigned CNT_W = 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SWAP,
    S_MUL,
    S_DIV,
    S_UPDATE,
    S_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ONE,
    RES_QUOT,
    RES_SAT
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     check;
    logic     swap;
    logic     clr_acc;
    logic     pp_en;
    logic [1:0] pp_sel;
    logic     acc_en;
    logic [1:0] acc_sel;
    logic     div_en;
    logic     step_update;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } bc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic k_gt_n;
    logic k_zero;
    logic k_eq_n;
    logic q_ovf;
    logic last_step;
    logic out_free;
  } bc_stat_t;

endpackage

>>> rtl/bc_ctrl.sv
// Controller state machine of the binomial coefficient core.
// Depends on bc_pkg for the state, command and status types.
`timescale 1ns / 1ps

module bc_ctrl import bc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bc_stat_t stat_i,
  output bc_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // State and phase counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (stat_i.k_gt_n) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ZERO;
          state_d        = S_OUT;
        end else if (stat_i.k_zero || stat_i.k_eq_n) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ONE;
          state_d        = S_OUT;
        end else begin
          state_d = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd_o.swap    = 1'b1;
        cmd_o.clr_acc = 1'b1;
        cnt_d         = '0;
        state_d       = S_MUL;
      end
      S_MUL: begin
        // Partial product for phase cnt, accumulation of the one before.
        cmd_o.pp_en   = (cnt_q < CNT_W'(PP_COUNT));
        cmd_o.pp_sel  = cnt_q[1:0];
        cmd_o.acc_en  = (cnt_q != '0);
        cmd_o.acc_sel = cnt_q[1:0] - 2'd1;
        if (cnt_q == CNT_W'(PP_COUNT)) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
          cnt_d   = '0;
          state_d = S_UPDATE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_UPDATE: begin
        if (stat_i.q_ovf) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_SAT;
          state_d        = S_OUT;
        end else if (stat_i.last_step) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_QUOT;
          state_d        = S_OUT;
        end else begin
          cmd_o.step_update = 1'b1;
          cmd_o.clr_acc     = 1'b1;
          cnt_d             = '0;
          state_d           = S_MUL;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/bc_dp.sv
// Datapath of the binomial coefficient core: operand registers, a 32x32
// multiplier, a radix-16 restoring divider and the output register.
// Depends on bc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bc_dp import bc_pkg::*; #(
  parameter int unsigned RESULT_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DATA_W-1:0] total_count_i,
  input  logic [DATA_W-1:0] chosen_count_i,
  input  bc_cmd_t           cmd_i,
  output bc_stat_t          stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] coefficient_o,
  output logic              overflow_o
);

  // All ones in the low RESULT_WIDTH bits.
  localparam logic [DATA_W:0] SatWide =
    ({{DATA_W{1'b0}}, 1'b1} << RESULT_WIDTH) - {{DATA_W{1'b0}}, 1'b1};
  localparam logic [DATA_W-1:0] SatValue = SatWide[DATA_W-1:0];

  logic [DATA_W-1:0] n_q, k_q, nk_q, r_q;
  logic [PROD_W-1:0] acc_q;
  logic [DATA_W-1:0] pp_q;
  logic [STEP_W-1:0] rem_q, div_q;
  logic [DATA_W-1:0] res_q;
  logic              res_ovf_q;
  logic              m_valid_q;
  logic [DATA_W-1:0] m_data_q;
  logic              m_user_q;

  logic [DATA_W:0]   diff;
  logic [HALF_W-1:0] a_half, b_half;
  logic [PROD_W-1:0] pp_ext, pp_shift;
  logic [PROD_W-1:0] acc_div;
  logic [STEP_W-1:0] rem_div;

  // Range checks of k against n, and n - k.
  assign diff = {1'b0, n_q} - {1'b0, k_q};

  // Operand halves for the current partial product.
  assign a_half = cmd_i.pp_sel[1] ? r_q[DATA_W-1:HALF_W] : r_q[HALF_W-1:0];
  assign b_half = cmd_i.pp_sel[0] ? n_q[DATA_W-1:HALF_W] : n_q[HALF_W-1:0];

  // Align the registered partial product by the sum of its half indexes.
  always_comb begin
    pp_ext = {{(PROD_W - DATA_W){1'b0}}, pp_q};
    unique case (cmd_i.acc_sel)
      2'b00:        pp_shift = pp_ext;
      2'b01, 2'b10: pp_shift = pp_ext << HALF_W;
      2'b11:        pp_shift = pp_ext << DATA_W;
      default:      pp_shift = pp_ext;
    endcase
  end

  // One radix-16 division cycle: four restoring steps on the narrow remainder.
  always_comb begin
    logic [STEP_W:0] trial;
    logic            qbit;
    acc_div = acc_q;
    rem_div = rem_q;
    for (int j = 0; j < DIGIT_W; j++) begin
      trial = {rem_div, acc_div[PROD_W-1]};
      qbit  = (trial >= {1'b0, div_q});
      if (qbit) begin
        trial = trial - {1'b0, div_q};
      end
      rem_div = trial[STEP_W-1:0];
      acc_div = {acc_div[PROD_W-2:0], qbit};
    end
  end

  // Status toward the controller.
  assign stat_o.k_gt_n    = diff[DATA_W];
  assign stat_o.k_eq_n    = (diff[DATA_W-1:0] == '0);
  assign stat_o.k_zero    = (k_q == '0);
  assign stat_o.q_ovf     = |acc_q[PROD_W-1:RESULT_WIDTH];
  assign stat_o.last_step = ({{(DATA_W - STEP_W){1'b0}}, div_q} == k_q);
  assign stat_o.out_free  = !m_valid_q || out_ready_i;

  // Working registers of the recurrence.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      n_q   <= total_count_i;
      k_q   <= chosen_count_i;
      r_q   <= {{(DATA_W - 1){1'b0}}, 1'b1};
      div_q <= {{(STEP_W - 1){1'b0}}, 1'b1};
    end
    if (cmd_i.check) begin
      nk_q <= diff[DATA_W-1:0];
    end
    if (cmd_i.swap && (k_q > nk_q)) begin
      k_q <= nk_q;
    end
    if (cmd_i.pp_en) begin
      pp_q <= a_half * b_half;
    end
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + pp_shift;
    end else if (cmd_i.div_en) begin
      acc_q <= acc_div;
      rem_q <= rem_div;
    end
    if (cmd_i.step_update) begin
      r_q   <= acc_q[DATA_W-1:0];
      div_q <= div_q + STEP_W'(1);
      n_q   <= n_q - DATA_W'(1);
    end
  end

  // Final value of the item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      unique case (cmd_i.res_sel)
        RES_ZERO: begin
          res_q     <= '0;
          res_ovf_q <= 1'b0;
        end
        RES_ONE: begin
          res_q     <= {{(DATA_W - 1){1'b0}}, 1'b1};
          res_ovf_q <= 1'b0;
        end
        RES_QUOT: begin
          res_q     <= acc_q[DATA_W-1:0];
          res_ovf_q <= 1'b0;
        end
        RES_SAT: begin
          res_q     <= SatValue;
          res_ovf_q <= 1'b1;
        end
        default: begin
          res_q     <= '0;
          res_ovf_q <= 1'b0;
        end
      endcase
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_data_q <= res_q;
      m_user_q <= res_ovf_q;
    end
  end

  assign out_valid_o   = m_valid_q;
  assign coefficient_o = m_data_q;
  assign overflow_o    = m_user_q;

  // A finished item is only written into a free output register.
  `BC_ASSERT(a_out_load_free, clk_i, rst_ni,
    cmd_i.out_load |-> (!m_valid_q || out_ready_i), "output register overwritten")
  // The divisor i+1 is never zero while dividing.
  `BC_ASSERT_NEVER(a_div_zero, clk_i, rst_ni,
    cmd_i.div_en && (div_q == '0), "division by zero")
  // Every division cycle leaves a remainder below the divisor.
  `BC_ASSERT(a_rem_range, clk_i, rst_ni,
    $past(cmd_i.div_en) |-> (rem_q < div_q), "remainder out of range")
  // A flagged result always carries the saturated value.
  `BC_ASSERT(a_sat_value, clk_i, rst_ni,
    (m_valid_q && m_user_q) |-> (m_data_q == SatValue), "overflow without saturation")

endmodule

>>> rtl/binomial_coefficient_core.sv
// Binomial coefficient core: C(n,k) with saturation past RESULT_WIDTH bits.
// The result is 0 when k > n and 1 when k = 0 or k = n; otherwise the recurrence runs
// s = min(k, n-k) steps of multiply, divide and update, at most 34 before the value saturates.
// One item at a time; the next is taken once a result is in the output register, while it waits.
// Asynchronous active-low reset clears the controller and the output valid.
// Depends on bc_pkg, bc_ctrl and bc_dp.
`timescale 1ns / 1ps

module binomial_coefficient_core import bc_pkg::*; #(
  parameter int unsigned RESULT_WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input item.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PROD_W-1:0]   s_axis_tdata,   // [63:0] total_count, [127:64] chosen_count
  // Result item.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [DATA_W-1:0]   m_axis_tdata,   // [63:0] coefficient
  output logic                m_axis_tuser    // [0] overflow
);

  bc_cmd_t  cmd;
  bc_stat_t stat;

  // Sequencer.
  bc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and output register.
  bc_dp #(
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .total_count_i  (s_axis_tdata[DATA_W-1:0]),
    .chosen_count_i (s_axis_tdata[PROD_W-1:DATA_W]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .coefficient_o  (m_axis_tdata),
    .overflow_o     (m_axis_tuser)
  );

endmodule

>>> tb/binomial_coefficient_core_tb.sv
// Self-checking testbench for binomial_coefficient_core: directed table, then random n and k.
// Depends on bc_pkg for the port widths and on the core itself; needs no files or arguments.
`timescale 1ns / 1ps

module binomial_coefficient_core_tb;
  import bc_pkg::*;

  localparam int unsigned RESULT_WIDTH = 64;
  localparam logic [63:0] COEF_MAX = {64{1'b1}} >> (64 - RESULT_WIDTH);
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned RANDOM_ITEMS = 225;
  // Receiver hold-off, long enough for two worst-case items to finish.
  localparam int unsigned HOLD_CYCLES = 4000;
  localparam int unsigned HOLD_AFTER_RESULTS = 40;
  localparam int unsigned DRAIN_CYCLES = 1500;

  // One result item as the core reports it.
  typedef struct packed {
    logic [63:0] coefficient;
    logic        overflow;
  } binom_res_t;

  // One row of the directed table; typed rows carry their expected result.
  typedef struct packed {
    logic [63:0] total_count;
    logic [63:0] chosen_count;
    logic        typed;
    logic [63:0] coefficient;
    logic        overflow;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // Empty set, k above n, k zero and k equal to n.
    '{64'd0, 64'd0, 1'b1, 64'd1, 1'b0},
    '{64'd0, 64'd1, 1'b1, 64'd0, 1'b0},
    '{64'd0, ALL_ONES, 1'b1, 64'd0, 1'b0},
    '{64'd5, 64'd0, 1'b1, 64'd1, 1'b0},
    '{64'd5, 64'd5, 1'b1, 64'd1, 1'b0},
    '{64'd5, 64'd6, 1'b1, 64'd0, 1'b0},
    '{ALL_ONES, 64'd0, 1'b1, 64'd1, 1'b0},
    '{ALL_ONES, ALL_ONES, 1'b1, 64'd1, 1'b0},
    '{ALL_ONES - 64'd1, ALL_ONES, 1'b1, 64'd0, 1'b0},
    // C(n,1) = n fits exactly even at the top of the range, also after the swap.
    '{ALL_ONES, 64'd1, 1'b1, ALL_ONES, 1'b0},
    '{ALL_ONES, ALL_ONES - 64'd1, 1'b1, ALL_ONES, 1'b0},
    // Saturation on the second step and with a huge k.
    '{ALL_ONES, 64'd2, 1'b1, COEF_MAX, 1'b1},
    '{ALL_ONES, 64'h8000_0000_0000_0000, 1'b1, COEF_MAX, 1'b1},
    // Ordinary values, the swap to n-k and the edge of the 64-bit range.
    '{64'd2, 64'd1, 1'b0, 64'd0, 1'b0},
    '{64'd10, 64'd3, 1'b0, 64'd0, 1'b0},
    '{64'd10, 64'd7, 1'b0, 64'd0, 1'b0},
    '{64'd62, 64'd31, 1'b0, 64'd0, 1'b0},
    '{64'd66, 64'd33, 1'b0, 64'd0, 1'b0},
    '{64'd67, 64'd33, 1'b0, 64'd0, 1'b0},
    '{64'd67, 64'd34, 1'b0, 64'd0, 1'b0},
    '{64'd68, 64'd34, 1'b0, 64'd0, 1'b0},
    '{64'd68, 64'd33, 1'b0, 64'd0, 1'b0},
    '{64'h1_0000_0000, 64'd2, 1'b0, 64'd0, 1'b0},
    '{64'h2_0000_0000, 64'd2, 1'b0, 64'd0, 1'b0},
    '{64'd100, 64'd50, 1'b0, 64'd0, 1'b0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [PROD_W-1:0] s_axis_tdata = '0;   // [63:0] total_count, [127:64] chosen_count
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // [63:0] coefficient
  logic              m_axis_tuser;        // [0] overflow

  binom_res_t  expected_coefs [$];
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;

  binomial_coefficient_core #(
    .RESULT_WIDTH(RESULT_WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Exact C(n,k) with a 128-bit product, saturating once the value leaves the result width.
  function automatic binom_res_t binomial_of(input logic [63:0] total,
                                             input logic [63:0] chosen);
    logic [127:0] product;
    logic [127:0] quotient;
    logic [63:0]  running;
    logic [63:0]  steps;
    logic [63:0]  step;
    binom_res_t   res;
    res.coefficient = '0;
    res.overflow    = 1'b0;
    if (chosen > total) return res;
    if (chosen == 64'd0 || chosen == total) begin
      res.coefficient = 64'd1;
      return res;
    end
    steps   = (chosen > total - chosen) ? total - chosen : chosen;
    running = 64'd1;
    // The loop ends within about 34 steps: larger k always saturates first.
    for (step = 64'd0; step < steps; step++) begin
      product  = {64'd0, running} * {64'd0, total - step};
      quotient = product / ({64'd0, step} + 128'd1);
      if (quotient > {64'd0, COEF_MAX}) begin
        res.coefficient = COEF_MAX;
        res.overflow    = 1'b1;
        return res;
      end
      running = quotient[63:0];
    end
    res.coefficient = running & COEF_MAX;
    return res;
  endfunction

  // Offers one item in bursts with random gaps and records its expectation once accepted.
  task automatic offer_item(input logic [63:0] total, input logic [63:0] chosen,
                            input logic typed, input binom_res_t typed_res);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      // Now and then a long burst with no idling at all.
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {chosen, total};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_coefs.push_back(typed ? typed_res : binomial_of(total, chosen));
    burst_left--;
  endtask

  // Stimulus: reset, the directed table, then random items of several kinds.
  initial begin : stimulus
    logic [63:0] total;
    logic [63:0] chosen;
    binom_res_t  typed_res;
    int unsigned kind;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int row = 0; row < DIR_ROWS; row++) begin
      typed_res.coefficient = DIR_TAB[row].coefficient;
      typed_res.overflow    = DIR_TAB[row].overflow;
      offer_item(DIR_TAB[row].total_count, DIR_TAB[row].chosen_count,
                 DIR_TAB[row].typed, typed_res);
    end

    typed_res = '0;
    for (int item = 0; item < RANDOM_ITEMS; item++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        // Small n with every k, the bulk of the long recurrences.
        0, 1, 2: begin
          total  = 64'($urandom_range(0, 70));
          chosen = 64'($urandom_range(0, int'(total) + 1));
        end
        // Around the middle of the rows where C(n,n/2) crosses 64 bits.
        3: begin
          total  = 64'($urandom_range(60, 75));
          chosen = total / 2 + 64'($urandom_range(0, 6)) - 64'd3;
        end
        // Huge n with a tiny k, or with k close to n so that the swap applies.
        4: begin
          total  = {$urandom, $urandom};
          chosen = 64'($urandom_range(0, 3));
        end
        5: begin
          total  = {$urandom, $urandom};
          chosen = total - 64'($urandom_range(0, 3));
        end
        // Full-width random bits on both fields.
        6: begin
          total  = {$urandom, $urandom};
          chosen = {$urandom, $urandom};
        end
        // k just above n.
        7: begin
          total  = {$urandom, $urandom} >> $urandom_range(0, 63);
          chosen = total + 64'($urandom_range(1, 1000));
        end
        // n near a power of two where k = 2 or 3 starts to saturate.
        8: begin
          total  = (64'd1 << $urandom_range(20, 40)) + 64'($urandom_range(0, 3));
          chosen = 64'($urandom_range(2, 3));
        end
        default: begin
          total  = {$urandom, $urandom} >> $urandom_range(40, 63);
          chosen = 64'($urandom_range(0, 6));
        end
      endcase
      offer_item(total, chosen, 1'b0, typed_res);
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then give any stray result time to show up.
    while (expected_coefs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver ready: random stall modes, plus one long hold-off that backs the core up.
  initial begin : rx_stall_pattern
    int unsigned mode;
    int unsigned run;
    logic        held_off;
    run      = 0;
    mode     = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held_off && results_seen >= HOLD_AFTER_RESULTS) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (run == 0) begin
        mode = $urandom_range(0, 3);
        run  = $urandom_range(8, 64);
      end
      run--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= run[0];
      endcase
    end
  end

  // Result checker: compares each accepted item with the oldest expectation.
  always @(posedge clk_i) begin
    binom_res_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_coefs.size() == 0) begin
        $error("result item with no expectation waiting: coefficient %h overflow %b",
               m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        exp_res = expected_coefs.pop_front();
        if (m_axis_tdata !== exp_res.coefficient) begin
          $error("coefficient: expected %h, got %h", exp_res.coefficient, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser !== exp_res.overflow) begin
          $error("overflow: expected %b, got %b", exp_res.overflow, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog, several times the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
